>>> src/quaternion_rotate_vector_unit_assert.svh
// Assertion macros shared by the quaternion rotation unit.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef QUATERNION_ROTATE_VECTOR_UNIT_ASSERT_SVH
`define QUATERNION_ROTATE_VECTOR_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define QRV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrv assertion failed");

// The consequence must hold in the cycle after the trigger.
`define QRV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrv assertion failed");

`endif

>>> src/qrv_pkg.sv
// Types, widths, register codes and multiply helpers of the quaternion rotation unit.
// Used by qrv_round_sat and quaternion_rotate_vector_unit; depends on nothing.
package qrv_pkg;

  localparam int QuatW     = 16;
  localparam int VecW      = 32;
  localparam int Prod1W    = 48;
  localparam int InterW    = 50;
  localparam int Prod2W    = 66;
  localparam int AccW      = 68;
  localparam int OutW      = 32;
  localparam int FracShift = 28;
  localparam int NumAxes   = 3;
  localparam int NumComps  = 4;
  localparam int NumTerms  = 4;
  localparam int NumStages = 5;

  localparam int AxisX = 0;
  localparam int AxisY = 1;
  localparam int AxisZ = 2;

  typedef enum logic [1:0] {
    CFG_QUAT_X = 2'd0,
    CFG_QUAT_Y = 2'd1,
    CFG_QUAT_Z = 2'd2,
    CFG_QUAT_W = 2'd3
  } cfg_idx_e;

  typedef logic signed [QuatW-1:0]  quat_t;
  typedef logic signed [VecW-1:0]   vec_t;
  typedef logic signed [Prod1W-1:0] prod1_t;
  typedef logic signed [InterW-1:0] inter_t;
  typedef logic signed [Prod2W-1:0] prod2_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic signed [OutW-1:0]   rot_t;

  localparam quat_t QuatWReset = 16'sd16384;
  localparam acc_t  RoundHalf  = acc_t'(1) <<< (FracShift - 1);

  function automatic prod1_t mul_qv(quat_t q, vec_t v);
    return prod1_t'(q) * prod1_t'(v);
  endfunction

  function automatic prod2_t mul_iq(inter_t i, quat_t q);
    return prod2_t'(i) * prod2_t'(q);
  endfunction

endpackage

>>> src/qrv_round_sat.sv
// Scales a rounded accumulator down by the fraction shift and saturates it to 32 bits.
// Depends on qrv_pkg for the accumulator and result types.
module qrv_round_sat (
  input  qrv_pkg::acc_t acc_i,
  output qrv_pkg::rot_t rot_o
);

  localparam int HiLsb = qrv_pkg::FracShift + qrv_pkg::OutW - 1;

  logic [qrv_pkg::AccW-1-HiLsb:0] hi;

  assign hi = acc_i[qrv_pkg::AccW-1:HiLsb];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      rot_o = qrv_pkg::rot_t'(acc_i[HiLsb:qrv_pkg::FracShift]);
    end else if (hi[$high(hi)]) begin
      rot_o = {1'b1, {(qrv_pkg::OutW-1){1'b0}}};
    end else begin
      rot_o = {1'b0, {(qrv_pkg::OutW-1){1'b1}}};
    end
  end

endmodule

>>> src/quaternion_rotate_vector_unit.sv
// Top level of the quaternion rotation unit: q * v * conj(q) over a five-stage pipeline.
// Depends on qrv_pkg, qrv_round_sat and quaternion_rotate_vector_unit_assert.svh.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_ready_o   vec_x_i, vec_y_i, vec_z_i
//   output    out        out_valid_o / out_ready_i rot_x_o, rot_y_o, rot_z_o
//   config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One request is taken every cycle unless the pipeline is full and stalled.
// The stages are the first products, the intermediate quaternion, the second products,
// the rounded sums, and the saturated output register.
// Reset empties every stage and loads the identity quaternion.
// Each stage holds while the stage after it is full and stalled, so bubbles still fill.
module quaternion_rotate_vector_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [qrv_pkg::QuatW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [qrv_pkg::VecW-1:0]    vec_x_i,
  input  logic signed [qrv_pkg::VecW-1:0]    vec_y_i,
  input  logic signed [qrv_pkg::VecW-1:0]    vec_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [qrv_pkg::OutW-1:0]    rot_x_o,
  output logic signed [qrv_pkg::OutW-1:0]    rot_y_o,
  output logic signed [qrv_pkg::OutW-1:0]    rot_z_o
);

  `include "quaternion_rotate_vector_unit_assert.svh"

  localparam int Last = qrv_pkg::NumStages - 1;

  qrv_pkg::quat_t  quat_q [qrv_pkg::NumComps];
  qrv_pkg::vec_t   vec    [qrv_pkg::NumAxes];

  qrv_pkg::prod1_t p1_d   [qrv_pkg::NumComps][qrv_pkg::NumAxes];
  qrv_pkg::prod1_t p1_q   [qrv_pkg::NumComps][qrv_pkg::NumAxes];
  qrv_pkg::inter_t i_d    [qrv_pkg::NumComps];
  qrv_pkg::inter_t i_q    [qrv_pkg::NumComps];
  qrv_pkg::prod2_t p2_d   [qrv_pkg::NumAxes][qrv_pkg::NumTerms];
  qrv_pkg::prod2_t p2_q   [qrv_pkg::NumAxes][qrv_pkg::NumTerms];
  qrv_pkg::acc_t   acc_d  [qrv_pkg::NumAxes];
  qrv_pkg::acc_t   acc_q  [qrv_pkg::NumAxes];
  qrv_pkg::rot_t   rot_d  [qrv_pkg::NumAxes];
  qrv_pkg::rot_t   rot_q  [qrv_pkg::NumAxes];

  logic [qrv_pkg::NumStages-1:0] vld_d, vld_q, en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[qrv_pkg::CFG_QUAT_X] <= '0;
      quat_q[qrv_pkg::CFG_QUAT_Y] <= '0;
      quat_q[qrv_pkg::CFG_QUAT_Z] <= '0;
      quat_q[qrv_pkg::CFG_QUAT_W] <= qrv_pkg::QuatWReset;
    end else if (cfg_we_i) begin
      unique case (qrv_pkg::cfg_idx_e'(cfg_index_i))
        qrv_pkg::CFG_QUAT_X: quat_q[qrv_pkg::CFG_QUAT_X] <= cfg_wdata_i;
        qrv_pkg::CFG_QUAT_Y: quat_q[qrv_pkg::CFG_QUAT_Y] <= cfg_wdata_i;
        qrv_pkg::CFG_QUAT_Z: quat_q[qrv_pkg::CFG_QUAT_Z] <= cfg_wdata_i;
        qrv_pkg::CFG_QUAT_W: quat_q[qrv_pkg::CFG_QUAT_W] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage enables and valid bits.
  always_comb begin
    en[Last] = !vld_q[Last] || out_ready_i;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < qrv_pkg::NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[Last];

  // Stage one: every quaternion component times every coordinate.
  assign vec[qrv_pkg::AxisX] = vec_x_i;
  assign vec[qrv_pkg::AxisY] = vec_y_i;
  assign vec[qrv_pkg::AxisZ] = vec_z_i;

  always_comb begin
    for (int c = 0; c < qrv_pkg::NumComps; c++) begin
      for (int a = 0; a < qrv_pkg::NumAxes; a++) begin
        p1_d[c][a] = qrv_pkg::mul_qv(quat_q[c], vec[a]);
      end
    end
  end

  // Stage two: the intermediate quaternion q * (v, 0).
  always_comb begin
    i_d[qrv_pkg::CFG_QUAT_X] = qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_W][qrv_pkg::AxisX])
                             + qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_Y][qrv_pkg::AxisZ])
                             - qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_Z][qrv_pkg::AxisY]);
    i_d[qrv_pkg::CFG_QUAT_Y] = qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_W][qrv_pkg::AxisY])
                             + qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_Z][qrv_pkg::AxisX])
                             - qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_X][qrv_pkg::AxisZ]);
    i_d[qrv_pkg::CFG_QUAT_Z] = qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_W][qrv_pkg::AxisZ])
                             + qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_X][qrv_pkg::AxisY])
                             - qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_Y][qrv_pkg::AxisX]);
    i_d[qrv_pkg::CFG_QUAT_W] = -qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_X][qrv_pkg::AxisX])
                             - qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_Y][qrv_pkg::AxisY])
                             - qrv_pkg::inter_t'(p1_q[qrv_pkg::CFG_QUAT_Z][qrv_pkg::AxisZ]);
  end

  // Stage three: the products of the intermediate quaternion with conj(q).
  // The first and last term of each sum add, the middle two subtract.
  always_comb begin
    p2_d[qrv_pkg::AxisX][0] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_X],
                                              quat_q[qrv_pkg::CFG_QUAT_W]);
    p2_d[qrv_pkg::AxisX][1] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_W],
                                              quat_q[qrv_pkg::CFG_QUAT_X]);
    p2_d[qrv_pkg::AxisX][2] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_Y],
                                              quat_q[qrv_pkg::CFG_QUAT_Z]);
    p2_d[qrv_pkg::AxisX][3] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_Z],
                                              quat_q[qrv_pkg::CFG_QUAT_Y]);
    p2_d[qrv_pkg::AxisY][0] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_Y],
                                              quat_q[qrv_pkg::CFG_QUAT_W]);
    p2_d[qrv_pkg::AxisY][1] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_W],
                                              quat_q[qrv_pkg::CFG_QUAT_Y]);
    p2_d[qrv_pkg::AxisY][2] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_Z],
                                              quat_q[qrv_pkg::CFG_QUAT_X]);
    p2_d[qrv_pkg::AxisY][3] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_X],
                                              quat_q[qrv_pkg::CFG_QUAT_Z]);
    p2_d[qrv_pkg::AxisZ][0] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_Z],
                                              quat_q[qrv_pkg::CFG_QUAT_W]);
    p2_d[qrv_pkg::AxisZ][1] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_W],
                                              quat_q[qrv_pkg::CFG_QUAT_Z]);
    p2_d[qrv_pkg::AxisZ][2] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_X],
                                              quat_q[qrv_pkg::CFG_QUAT_Y]);
    p2_d[qrv_pkg::AxisZ][3] = qrv_pkg::mul_iq(i_q[qrv_pkg::CFG_QUAT_Y],
                                              quat_q[qrv_pkg::CFG_QUAT_X]);
  end

  // Stage four: the sums with the rounding half added in.
  always_comb begin
    for (int a = 0; a < qrv_pkg::NumAxes; a++) begin
      acc_d[a] = qrv_pkg::acc_t'(p2_q[a][0]) - qrv_pkg::acc_t'(p2_q[a][1])
               - qrv_pkg::acc_t'(p2_q[a][2]) + qrv_pkg::acc_t'(p2_q[a][3])
               + qrv_pkg::RoundHalf;
    end
  end

  // Stage five: scaling and saturation into the output register.
  for (genvar a = 0; a < qrv_pkg::NumAxes; a++) begin : g_sat
    qrv_round_sat u_round_sat (
      .acc_i (acc_q[a]),
      .rot_o (rot_d[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q <= p1_d;
    end
    if (en[1]) begin
      i_q <= i_d;
    end
    if (en[2]) begin
      p2_q <= p2_d;
    end
    if (en[3]) begin
      acc_q <= acc_d;
    end
    if (en[4]) begin
      rot_q <= rot_d;
    end
  end

  assign rot_x_o = rot_q[qrv_pkg::AxisX];
  assign rot_y_o = rot_q[qrv_pkg::AxisY];
  assign rot_z_o = rot_q[qrv_pkg::AxisZ];

  `QRV_ASSERT_NEXT(a_accept_fills_first, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[0])
  `QRV_ASSERT_IMPL(a_ready_needs_room, clk_i, rst_ni,
                   out_valid_o && !out_ready_i && in_ready_o, !(&vld_q[Last-1:0]))
  `QRV_ASSERT_NEXT(a_held_sum_stable, clk_i, rst_ni, vld_q[3] && !en[3],
                   vld_q[3] && $stable(acc_q[qrv_pkg::AxisX]))
  `QRV_ASSERT_NEXT(a_sum_reaches_output, clk_i, rst_ni, vld_q[3] && en[4], out_valid_o)

endmodule
